### rtl/dlcsc_pkg.sv
`default_nettype none

package dlcsc_pkg;

    localparam int SAMPLE_W = 24;
    localparam int WORD_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = SAMPLE_W + WORD_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int QUOT_W   = ACC_W - FRAC_W;
    localparam int IDX_W    = 3;
    localparam int KIND_W   = 2;

    localparam logic [IDX_W-1:0] REG_GAIN_RIGHT    = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_LEFT     = 3'd1;
    localparam logic [IDX_W-1:0] REG_ZERO_RIGHT    = 3'd2;
    localparam logic [IDX_W-1:0] REG_ZERO_LEFT     = 3'd3;
    localparam logic [IDX_W-1:0] REG_DUAL_MODE     = 3'd4;
    localparam logic [IDX_W-1:0] REG_RIGHT_FIRST   = 3'd5;
    localparam logic [IDX_W-1:0] REG_REPORT_EACH   = 3'd6;
    localparam logic [IDX_W-1:0] REG_REPORT_ENABLE = 3'd7;

    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LEFT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RIGHT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BOTH  = 2'd3;

    localparam logic signed [WORD_W-1:0] GAIN_ONE = 32'sd65536;

    typedef struct packed {
        logic                 left_side;
        logic [KIND_W-1:0]    kind;
        logic                 next_pair;
        logic                 left_pending;
        logic                 right_pending;
    } stage_ctl_t;

endpackage

`default_nettype wire

### rtl/dual_load_cell_sample_conditioner.sv
// Path: a sample moves from the input register to the result register.
// Throughput: one sample per cycle while in_stall is low; the input register and
// the result register form a two-entry pipeline, so in_stall rises only while
// both are full and out_stall is high.
// Reset: asynchronous, active low; configuration returns to its defaults,
// the first pair is selected, flags and stored values clear.
`default_nettype none

module dual_load_cell_sample_conditioner
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  cfg_we,
    input  wire logic [dlcsc_pkg::IDX_W-1:0]           cfg_index,
    input  wire logic [dlcsc_pkg::WORD_W-1:0]          cfg_data,

    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [dlcsc_pkg::SAMPLE_W-1:0] sample,

    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [dlcsc_pkg::KIND_W-1:0]               notify_kind,
    output logic signed [dlcsc_pkg::WORD_W-1:0]        force_left,
    output logic signed [dlcsc_pkg::WORD_W-1:0]        force_right,
    output logic signed [dlcsc_pkg::SAMPLE_W-1:0]      raw_left,
    output logic signed [dlcsc_pkg::SAMPLE_W-1:0]      raw_right,
    output logic                                       next_pair,
    output logic                                       left_pending,
    output logic                                       right_pending
);

    logic signed [dlcsc_pkg::WORD_W-1:0]   gain_right_reg;
    logic signed [dlcsc_pkg::WORD_W-1:0]   gain_left_reg;
    logic signed [dlcsc_pkg::WORD_W-1:0]   zero_right_reg;
    logic signed [dlcsc_pkg::WORD_W-1:0]   zero_left_reg;
    logic                                  dual_mode_reg;
    logic                                  right_first_reg;
    logic                                  report_each_reg;
    logic                                  report_enable_reg;

    logic                                  on_first_pair_reg;
    logic                                  on_first_pair_next;
    logic                                  left_flag_reg;
    logic                                  left_flag_next;
    logic                                  right_flag_reg;
    logic                                  right_flag_next;

    logic                                  s1_valid_reg;
    logic signed [dlcsc_pkg::SAMPLE_W-1:0] s1_sample_reg;
    dlcsc_pkg::stage_ctl_t                 s1_ctl_reg;
    dlcsc_pkg::stage_ctl_t                 s1_ctl_next;

    logic                                  out_valid_reg;
    logic [dlcsc_pkg::KIND_W-1:0]          kind_reg;
    logic signed [dlcsc_pkg::WORD_W-1:0]   force_left_reg;
    logic signed [dlcsc_pkg::WORD_W-1:0]   force_right_reg;
    logic signed [dlcsc_pkg::SAMPLE_W-1:0] raw_left_reg;
    logic signed [dlcsc_pkg::SAMPLE_W-1:0] raw_right_reg;
    logic                                  next_pair_reg;
    logic                                  left_pending_reg;
    logic                                  right_pending_reg;

    logic                                  in_acc;
    logic                                  adv_out;
    logic                                  side_left;
    logic                                  lf_set;
    logic                                  rf_set;
    logic                                  rep_left;
    logic                                  rep_right;

    logic signed [dlcsc_pkg::WORD_W-1:0]   sel_gain;
    logic signed [dlcsc_pkg::WORD_W-1:0]   sel_zero;
    logic signed [dlcsc_pkg::PROD_W-1:0]   prod;
    logic signed [dlcsc_pkg::ACC_W-1:0]    acc;
    logic signed [dlcsc_pkg::QUOT_W-1:0]   quot;
    logic signed [dlcsc_pkg::WORD_W-1:0]   force_sat;

    assign adv_out  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !(!out_valid_reg || !out_stall);
    assign in_acc   = in_valid && !in_stall;

    // side selection, pair toggle and report flags for the accepted item
    always_comb
    begin
        side_left = (on_first_pair_reg != right_first_reg);
        lf_set    = left_flag_reg || side_left;
        rf_set    = right_flag_reg || !side_left;
        rep_left  = 1'b0;
        rep_right = 1'b0;
        if (report_enable_reg)
        begin
            if (report_each_reg)
            begin
                rep_left  = lf_set;
                rep_right = rf_set;
            end
            else if (lf_set && rf_set)
            begin
                rep_left  = 1'b1;
                rep_right = 1'b1;
            end
        end
        on_first_pair_next = dual_mode_reg ? !on_first_pair_reg : on_first_pair_reg;
        left_flag_next     = lf_set && !rep_left;
        right_flag_next    = rf_set && !rep_right;

        s1_ctl_next.left_side     = side_left;
        s1_ctl_next.kind          = {rep_right, rep_left};
        s1_ctl_next.next_pair     = !on_first_pair_next;
        s1_ctl_next.left_pending  = left_flag_next;
        s1_ctl_next.right_pending = right_flag_next;
    end

    // scale, offset, round half up, saturate
    always_comb
    begin
        sel_gain = s1_ctl_reg.left_side ? gain_left_reg : gain_right_reg;
        sel_zero = s1_ctl_reg.left_side ? zero_left_reg : zero_right_reg;
        prod     = dlcsc_pkg::PROD_W'(s1_sample_reg) * dlcsc_pkg::PROD_W'(sel_gain);
        acc      = dlcsc_pkg::ACC_W'(prod)
                 - (dlcsc_pkg::ACC_W'(sel_zero) <<< dlcsc_pkg::FRAC_W)
                 + (dlcsc_pkg::ACC_W'(1) <<< (dlcsc_pkg::FRAC_W - 1));
        quot     = dlcsc_pkg::QUOT_W'(acc >>> dlcsc_pkg::FRAC_W);
        if (quot[dlcsc_pkg::QUOT_W-1:dlcsc_pkg::WORD_W-1] == '0
            || quot[dlcsc_pkg::QUOT_W-1:dlcsc_pkg::WORD_W-1] == '1)
        begin
            force_sat = quot[dlcsc_pkg::WORD_W-1:0];
        end
        else if (quot[dlcsc_pkg::QUOT_W-1])
        begin
            force_sat = {1'b1, {(dlcsc_pkg::WORD_W-1){1'b0}}};
        end
        else
        begin
            force_sat = {1'b0, {(dlcsc_pkg::WORD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_right_reg    <= dlcsc_pkg::GAIN_ONE;
            gain_left_reg     <= dlcsc_pkg::GAIN_ONE;
            zero_right_reg    <= '0;
            zero_left_reg     <= '0;
            dual_mode_reg     <= 1'b1;
            right_first_reg   <= 1'b1;
            report_each_reg   <= 1'b0;
            report_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dlcsc_pkg::REG_GAIN_RIGHT:    gain_right_reg    <= cfg_data;
                dlcsc_pkg::REG_GAIN_LEFT:     gain_left_reg     <= cfg_data;
                dlcsc_pkg::REG_ZERO_RIGHT:    zero_right_reg    <= cfg_data;
                dlcsc_pkg::REG_ZERO_LEFT:     zero_left_reg     <= cfg_data;
                dlcsc_pkg::REG_DUAL_MODE:     dual_mode_reg     <= cfg_data[0];
                dlcsc_pkg::REG_RIGHT_FIRST:   right_first_reg   <= cfg_data[0];
                dlcsc_pkg::REG_REPORT_EACH:   report_each_reg   <= cfg_data[0];
                dlcsc_pkg::REG_REPORT_ENABLE: report_enable_reg <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_first_pair_reg <= 1'b1;
            left_flag_reg     <= 1'b0;
            right_flag_reg    <= 1'b0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                on_first_pair_reg <= on_first_pair_next;
                left_flag_reg     <= left_flag_next;
                right_flag_reg    <= right_flag_next;
                s1_valid_reg      <= 1'b1;
            end
            else if (adv_out)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_sample_reg <= sample;
            s1_ctl_reg    <= s1_ctl_next;
        end
    end

    // stored force and raw values live in the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            force_left_reg  <= '0;
            force_right_reg <= '0;
            raw_left_reg    <= '0;
            raw_right_reg   <= '0;
        end
        else
        begin
            if (adv_out)
            begin
                out_valid_reg <= 1'b1;
                if (s1_ctl_reg.left_side)
                begin
                    force_left_reg <= force_sat;
                    raw_left_reg   <= s1_sample_reg;
                end
                else
                begin
                    force_right_reg <= force_sat;
                    raw_right_reg   <= s1_sample_reg;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            kind_reg          <= s1_ctl_reg.kind;
            next_pair_reg     <= s1_ctl_reg.next_pair;
            left_pending_reg  <= s1_ctl_reg.left_pending;
            right_pending_reg <= s1_ctl_reg.right_pending;
        end
    end

    assign out_valid     = out_valid_reg;
    assign notify_kind   = kind_reg;
    assign force_left    = force_left_reg;
    assign force_right   = force_right_reg;
    assign raw_left      = raw_left_reg;
    assign raw_right     = raw_right_reg;
    assign next_pair     = next_pair_reg;
    assign left_pending  = left_pending_reg;
    assign right_pending = right_pending_reg;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (!s1_valid_reg || adv_out))
        else $error("item accepted into a full input register");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv_out |=> out_valid_reg)
        else $error("result register not loaded on advance");

    a_each_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && report_enable_reg && report_each_reg) |=> (!left_flag_reg && !right_flag_reg))
        else $error("flags left pending in single report mode");

    a_pair_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && dual_mode_reg) |=> (on_first_pair_reg != $past(on_first_pair_reg)))
        else $error("input pair did not toggle in dual mode");

endmodule

`default_nettype wire

### tb/sv/load_cell_checker.sv
`timescale 1ns / 1ps

module load_cell_checker
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  cfg_we,
    input  wire logic [dlcsc_pkg::IDX_W-1:0]           cfg_index,
    input  wire logic [dlcsc_pkg::WORD_W-1:0]          cfg_data,

    input  wire logic                                  in_valid,
    input  wire logic                                  in_stall,
    input  wire logic signed [dlcsc_pkg::SAMPLE_W-1:0] sample,

    input  wire logic                                  out_valid,
    input  wire logic                                  out_stall,
    input  wire logic [dlcsc_pkg::KIND_W-1:0]          notify_kind,
    input  wire logic signed [dlcsc_pkg::WORD_W-1:0]   force_left,
    input  wire logic signed [dlcsc_pkg::WORD_W-1:0]   force_right,
    input  wire logic signed [dlcsc_pkg::SAMPLE_W-1:0] raw_left,
    input  wire logic signed [dlcsc_pkg::SAMPLE_W-1:0] raw_right,
    input  wire logic                                  next_pair,
    input  wire logic                                  left_pending,
    input  wire logic                                  right_pending,

    output int                                         fail_count,
    output int                                         outstanding
);

    typedef struct packed {
        logic [dlcsc_pkg::KIND_W-1:0]          kind;
        logic signed [dlcsc_pkg::WORD_W-1:0]   force_left;
        logic signed [dlcsc_pkg::WORD_W-1:0]   force_right;
        logic signed [dlcsc_pkg::SAMPLE_W-1:0] raw_left;
        logic signed [dlcsc_pkg::SAMPLE_W-1:0] raw_right;
        logic                                  next_pair;
        logic                                  left_pending;
        logic                                  right_pending;
    } cell_report_t;

    logic signed [dlcsc_pkg::WORD_W-1:0]   gain_right;
    logic signed [dlcsc_pkg::WORD_W-1:0]   gain_left;
    logic signed [dlcsc_pkg::WORD_W-1:0]   zero_right;
    logic signed [dlcsc_pkg::WORD_W-1:0]   zero_left;
    logic                                  dual_mode;
    logic                                  right_first;
    logic                                  report_each;
    logic                                  report_enable;

    logic                                  first_pair;
    logic                                  left_flag;
    logic                                  right_flag;
    logic signed [dlcsc_pkg::WORD_W-1:0]   left_force;
    logic signed [dlcsc_pkg::WORD_W-1:0]   right_force;
    logic signed [dlcsc_pkg::SAMPLE_W-1:0] left_raw;
    logic signed [dlcsc_pkg::SAMPLE_W-1:0] right_raw;

    cell_report_t due_reports[$];
    cell_report_t want;

    // round half up, then clamp to 32 bits
    function automatic logic signed [dlcsc_pkg::WORD_W-1:0] scaled_force(
        input logic signed [dlcsc_pkg::SAMPLE_W-1:0] value,
        input logic signed [dlcsc_pkg::WORD_W-1:0]   gain,
        input logic signed [dlcsc_pkg::WORD_W-1:0]   offset
    );
        longint acc;
        acc = longint'(value) * longint'(gain)
            - (longint'(offset) <<< dlcsc_pkg::FRAC_W) + 64'sd32768;
        acc = acc >>> dlcsc_pkg::FRAC_W;
        if (acc > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (acc < -64'sd2147483648)
            return 32'sh8000_0000;
        return acc[dlcsc_pkg::WORD_W-1:0];
    endfunction

    function automatic cell_report_t condition_sample(
        input logic signed [dlcsc_pkg::SAMPLE_W-1:0] value
    );
        cell_report_t r;
        if (first_pair != right_first)
        begin
            left_force = scaled_force(value, gain_left, zero_left);
            left_raw   = value;
            left_flag  = 1'b1;
        end
        else
        begin
            right_force = scaled_force(value, gain_right, zero_right);
            right_raw   = value;
            right_flag  = 1'b1;
        end
        if (dual_mode)
            first_pair = !first_pair;
        r.kind = dlcsc_pkg::KIND_NONE;
        if (report_enable)
        begin
            if (report_each)
            begin
                if (left_flag)
                begin
                    r.kind    = r.kind | dlcsc_pkg::KIND_LEFT;
                    left_flag = 1'b0;
                end
                if (right_flag)
                begin
                    r.kind     = r.kind | dlcsc_pkg::KIND_RIGHT;
                    right_flag = 1'b0;
                end
            end
            else if (left_flag && right_flag)
            begin
                r.kind     = dlcsc_pkg::KIND_BOTH;
                left_flag  = 1'b0;
                right_flag = 1'b0;
            end
        end
        r.force_left    = left_force;
        r.force_right   = right_force;
        r.raw_left      = left_raw;
        r.raw_right     = right_raw;
        r.next_pair     = !first_pair;
        r.left_pending  = left_flag;
        r.right_pending = right_flag;
        return r;
    endfunction

    task automatic compare_field(
        input string              name,
        input logic signed [63:0] want_v,
        input logic signed [63:0] got_v
    );
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_right    = dlcsc_pkg::GAIN_ONE;
            gain_left     = dlcsc_pkg::GAIN_ONE;
            zero_right    = '0;
            zero_left     = '0;
            dual_mode     = 1'b1;
            right_first   = 1'b1;
            report_each   = 1'b0;
            report_enable = 1'b1;
            first_pair    = 1'b1;
            left_flag     = 1'b0;
            right_flag    = 1'b0;
            left_force    = '0;
            right_force   = '0;
            left_raw      = '0;
            right_raw     = '0;
            due_reports.delete();
            fail_count    = 0;
            outstanding  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_reports.size() == 0)
                begin
                    $error("result item with no sample waiting");
                    fail_count++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    compare_field("notify_kind", want.kind, notify_kind);
                    compare_field("force_left", want.force_left, force_left);
                    compare_field("force_right", want.force_right, force_right);
                    compare_field("raw_left", want.raw_left, raw_left);
                    compare_field("raw_right", want.raw_right, raw_right);
                    compare_field("next_pair", want.next_pair, next_pair);
                    compare_field("left_pending", want.left_pending, left_pending);
                    compare_field("right_pending", want.right_pending, right_pending);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    dlcsc_pkg::REG_GAIN_RIGHT:    gain_right    = cfg_data;
                    dlcsc_pkg::REG_GAIN_LEFT:     gain_left     = cfg_data;
                    dlcsc_pkg::REG_ZERO_RIGHT:    zero_right    = cfg_data;
                    dlcsc_pkg::REG_ZERO_LEFT:     zero_left     = cfg_data;
                    dlcsc_pkg::REG_DUAL_MODE:     dual_mode     = cfg_data[0];
                    dlcsc_pkg::REG_RIGHT_FIRST:   right_first   = cfg_data[0];
                    dlcsc_pkg::REG_REPORT_EACH:   report_each   = cfg_data[0];
                    dlcsc_pkg::REG_REPORT_ENABLE: report_enable = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                due_reports.push_back(condition_sample(sample));
            outstanding <= due_reports.size();
        end
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic signed [dlcsc_pkg::WORD_W-1:0] gain_right;
        logic signed [dlcsc_pkg::WORD_W-1:0] gain_left;
        logic signed [dlcsc_pkg::WORD_W-1:0] zero_right;
        logic signed [dlcsc_pkg::WORD_W-1:0] zero_left;
        logic                                dual_mode;
        logic                                right_first;
        logic                                report_each;
        logic                                report_enable;
    } settings_t;

    logic                                  clk       = 1'b0;
    logic                                  rst_n     = 1'b0;
    logic                                  cfg_we    = 1'b0;
    logic [dlcsc_pkg::IDX_W-1:0]           cfg_index = '0;
    logic [dlcsc_pkg::WORD_W-1:0]          cfg_data  = '0;
    logic                                  in_valid  = 1'b0;
    logic                                  in_stall;
    logic signed [dlcsc_pkg::SAMPLE_W-1:0] sample    = '0;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    logic [dlcsc_pkg::KIND_W-1:0]          notify_kind;
    logic signed [dlcsc_pkg::WORD_W-1:0]   force_left;
    logic signed [dlcsc_pkg::WORD_W-1:0]   force_right;
    logic signed [dlcsc_pkg::SAMPLE_W-1:0] raw_left;
    logic signed [dlcsc_pkg::SAMPLE_W-1:0] raw_right;
    logic                                  next_pair;
    logic                                  left_pending;
    logic                                  right_pending;

    int        fail_count;
    int        outstanding;
    int        stall_hold = 0;
    bit        gapless    = 1'b0;
    settings_t cfg;

    dual_load_cell_sample_conditioner dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .notify_kind   (notify_kind),
        .force_left    (force_left),
        .force_right   (force_right),
        .raw_left      (raw_left),
        .raw_right     (raw_right),
        .next_pair     (next_pair),
        .left_pending  (left_pending),
        .right_pending (right_pending)
    );

    load_cell_checker check_u
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .notify_kind   (notify_kind),
        .force_left    (force_left),
        .force_right   (force_right),
        .raw_left      (raw_left),
        .raw_right     (raw_right),
        .next_pair     (next_pair),
        .left_pending  (left_pending),
        .right_pending (right_pending),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // stall runs reuse the gap lengths; stall on about a third of them
    always @(posedge clk)
    begin
        if (stall_hold > 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            stall_hold <= pick_gap();
        end
    end

    function automatic logic signed [dlcsc_pkg::WORD_W-1:0] random_word(input bit is_gain);
        case ($urandom_range(0, 5))
            0:       return is_gain ? dlcsc_pkg::GAIN_ONE : 32'sd0;
            1:       return 32'($urandom);
            2:       return 32'($urandom_range(0, 1 << 18) - (1 << 17));
            3:       return 32'sh7FFF_FFFF;
            4:       return 32'sh8000_0000;
            default: return is_gain ? -dlcsc_pkg::GAIN_ONE
                                    : 32'($urandom_range(0, 4000) - 2000);
        endcase
    endfunction

    function automatic logic signed [dlcsc_pkg::SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return 24'sh7F_FFFF;
            1:       return 24'sh80_0000;
            2, 3:    return 24'($urandom_range(0, 2000) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic settings_t random_settings();
        settings_t s;
        s.gain_right    = random_word(1'b1);
        s.gain_left     = random_word(1'b1);
        s.zero_right    = random_word(1'b0);
        s.zero_left     = random_word(1'b0);
        s.dual_mode     = ($urandom_range(0, 3) != 0);
        s.right_first   = 1'($urandom_range(0, 1));
        s.report_each   = 1'($urandom_range(0, 1));
        s.report_enable = ($urandom_range(0, 3) != 0);
        return s;
    endfunction

    task automatic write_reg(input logic [dlcsc_pkg::IDX_W-1:0] idx,
                             input logic [dlcsc_pkg::WORD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(input settings_t s);
        write_reg(dlcsc_pkg::REG_GAIN_RIGHT, s.gain_right);
        write_reg(dlcsc_pkg::REG_GAIN_LEFT, s.gain_left);
        write_reg(dlcsc_pkg::REG_ZERO_RIGHT, s.zero_right);
        write_reg(dlcsc_pkg::REG_ZERO_LEFT, s.zero_left);
        write_reg(dlcsc_pkg::REG_DUAL_MODE, {31'b0, s.dual_mode});
        write_reg(dlcsc_pkg::REG_RIGHT_FIRST, {31'b0, s.right_first});
        write_reg(dlcsc_pkg::REG_REPORT_EACH, {31'b0, s.report_each});
        write_reg(dlcsc_pkg::REG_REPORT_ENABLE, {31'b0, s.report_enable});
        cfg_we <= 1'b0;
    endtask

    // valid stays high across back-to-back items; drain lowers it
    task automatic send_sample(input logic signed [dlcsc_pkg::SAMPLE_W-1:0] value);
        int   gap;
        logic stalled;
        gap = gapless ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
    endtask

    task automatic drain();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (outstanding != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: unity gain, paired reporting, one side pending then both
        cfg.gain_right    = dlcsc_pkg::GAIN_ONE;
        cfg.gain_left     = dlcsc_pkg::GAIN_ONE;
        cfg.zero_right    = '0;
        cfg.zero_left     = '0;
        cfg.dual_mode     = 1'b1;
        cfg.right_first   = 1'b1;
        cfg.report_each   = 1'b0;
        cfg.report_enable = 1'b1;
        apply_settings(cfg);
        send_sample(24'sh7F_FFFF);
        send_sample(24'sh80_0000);
        send_sample(24'sd0);
        send_sample(-24'sd1);
        send_sample(24'sd1);
        drain();

        // extreme gains and offsets, saturation both ways
        cfg.gain_right  = 32'sh8000_0000;
        cfg.gain_left   = 32'sh7FFF_FFFF;
        cfg.zero_right  = 32'sh7FFF_FFFF;
        cfg.zero_left   = 32'sh8000_0000;
        cfg.right_first = 1'b0;
        cfg.report_each = 1'b1;
        apply_settings(cfg);
        send_sample(24'sh7F_FFFF);
        send_sample(24'sh7F_FFFF);
        send_sample(24'sh80_0000);
        send_sample(24'sh80_0000);
        send_sample(24'sd0);
        send_sample(24'sd0);
        drain();

        // half-step rounding with notifications off, both flags left set
        cfg.gain_right    = 32'sd1;
        cfg.gain_left     = 32'sd1;
        cfg.zero_right    = '0;
        cfg.zero_left     = '0;
        cfg.right_first   = 1'b1;
        cfg.report_each   = 1'b0;
        cfg.report_enable = 1'b0;
        apply_settings(cfg);
        send_sample(24'sd32768);
        send_sample(-24'sd32768);
        send_sample(24'sd32767);
        send_sample(-24'sd32769);
        drain();

        // per-side reporting picks up both pending flags at once
        cfg.gain_right    = dlcsc_pkg::GAIN_ONE;
        cfg.gain_left     = dlcsc_pkg::GAIN_ONE;
        cfg.report_each   = 1'b1;
        cfg.report_enable = 1'b1;
        apply_settings(cfg);
        send_sample(24'sd1234);
        send_sample(-24'sd4321);
        drain();

        // single pair, negative gain, nonzero offsets
        cfg.gain_right  = -dlcsc_pkg::GAIN_ONE;
        cfg.gain_left   = -dlcsc_pkg::GAIN_ONE;
        cfg.zero_right  = 32'sd7;
        cfg.zero_left   = -32'sd5;
        cfg.dual_mode   = 1'b0;
        cfg.right_first = 1'b0;
        apply_settings(cfg);
        send_sample(24'sd100);
        send_sample(-24'sd100);
        send_sample(24'sh7F_FFFF);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            gapless = (ph % 4 == 3);
            apply_settings(random_settings());
            repeat (125) send_sample(random_sample());
            drain();
        end

        if (outstanding != 0)
            $error("%0d result items never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
